>>> hdl/jsu_pkg.sv
// Shared types and constants for the JSON string unescaper.
package jsu_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic [1:0] status;
  } out_t;

  // One decoded step: up to four bytes, index of the last result, status.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last;
    logic            has_bytes;
    logic [1:0]      status;
  } res_t;

  typedef enum logic [3:0] {
    M_IDLE = 4'd0,
    M_STR  = 4'd1,
    M_ESC  = 4'd2,
    M_HEX  = 4'd3,
    M_PBS  = 4'd4,
    M_PU   = 4'd5,
    M_LOW  = 4'd6,
    M_ERR  = 4'd7
  } mode_t;

  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

endpackage

>>> hdl/jsu_decode.sv
// Decode state machine: holds the string state and turns one byte into a result group.
module jsu_decode (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         accept,
  input  jsu_pkg::in_t in_data,
  output jsu_pkg::res_t res
);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [15:0] HI_MIN = 16'hD800;
  localparam logic [15:0] HI_MAX = 16'hDBFF;
  localparam logic [15:0] LO_MIN = 16'hDC00;
  localparam logic [15:0] LO_MAX = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE = 21'h10000;
  localparam logic [20:0] REPL_CP   = 21'h0FFFD;
  localparam logic [20:0] LIM_1B    = 21'h00080;
  localparam logic [20:0] LIM_2B    = 21'h00800;
  localparam logic [7:0] LEAD_2B  = 8'hC0;
  localparam logic [7:0] LEAD_3B  = 8'hE0;
  localparam logic [7:0] LEAD_4B  = 8'hF0;
  localparam logic [7:0] CONT_B   = 8'h80;
  localparam logic [5:0] CONT_MSK = 6'h3F;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
  } enc_t;

  function automatic enc_t utf8_enc(input logic [20:0] cp);
    enc_t e;
    e.bytes = '0;
    if (cp < LIM_1B) begin
      e.bytes[0] = cp[7:0];
      e.count    = 3'd1;
    end else if (cp < LIM_2B) begin
      e.bytes[0] = LEAD_2B | {3'b000, cp[10:6]};
      e.bytes[1] = CONT_B | {2'b00, cp[5:0] & CONT_MSK};
      e.count    = 3'd2;
    end else if (cp < SUPP_BASE) begin
      e.bytes[0] = LEAD_3B | {4'b0000, cp[15:12]};
      e.bytes[1] = CONT_B | {2'b00, cp[11:6]};
      e.bytes[2] = CONT_B | {2'b00, cp[5:0]};
      e.count    = 3'd3;
    end else begin
      e.bytes[0] = LEAD_4B | {5'b00000, cp[20:18]};
      e.bytes[1] = CONT_B | {2'b00, cp[17:12]};
      e.bytes[2] = CONT_B | {2'b00, cp[11:6]};
      e.bytes[3] = CONT_B | {2'b00, cp[5:0]};
      e.count    = 3'd4;
    end
    return e;
  endfunction

  jsu_pkg::mode_t mode_r, mode_nxt;
  logic [15:0] accum_r, accum_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [15:0] hh_r, hh_nxt;

  logic [7:0]  c;
  logic        hexv;
  logic [3:0]  hexd;
  logic [15:0] acc_new;
  logic        hex_done;
  logic        new_hi, new_lo;
  logic        esc_ok;
  logic [7:0]  esc_chr;
  logic [20:0] pair_cp;

  assign c = in_data.in_byte;

  always_comb begin
    hexv = 1'b1;
    hexd = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      hexd = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      hexd = c[3:0] + 4'd9;
    end else begin
      hexv = 1'b0;
    end
  end

  assign acc_new  = {accum_r[11:0], hexd};
  assign hex_done = hexv && (cnt_r == 2'd3);
  assign new_hi   = (acc_new >= HI_MIN) && (acc_new <= HI_MAX);
  assign new_lo   = (acc_new >= LO_MIN) && (acc_new <= LO_MAX);
  assign pair_cp  = SUPP_BASE + {1'b0, hh_r[9:0], acc_new[9:0]};

  always_comb begin
    esc_ok  = 1'b1;
    esc_chr = c;
    case (c)
      CH_QUOTE, CH_BSLASH, CH_SLASH: esc_chr = c;
      CH_B:    esc_chr = 8'h08;
      CH_F:    esc_chr = 8'h0C;
      CH_N:    esc_chr = 8'h0A;
      CH_R:    esc_chr = 8'h0D;
      CH_T:    esc_chr = 8'h09;
      default: esc_ok  = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    mode_nxt  = mode_r;
    accum_nxt = accum_r;
    cnt_nxt   = cnt_r;
    hh_nxt    = hh_r;
    unique case (mode_r)
      jsu_pkg::M_IDLE: mode_nxt = (c == CH_QUOTE) ? jsu_pkg::M_STR : jsu_pkg::M_ERR;
      jsu_pkg::M_STR, jsu_pkg::M_PBS: begin
        if (c == CH_QUOTE) mode_nxt = jsu_pkg::M_IDLE;
        else if (c == CH_BSLASH) mode_nxt = (mode_r == jsu_pkg::M_PBS) ?
                                             jsu_pkg::M_PU : jsu_pkg::M_ESC;
        else mode_nxt = jsu_pkg::M_STR;
      end
      jsu_pkg::M_ESC, jsu_pkg::M_PU: begin
        if (c == CH_U) begin
          mode_nxt  = (mode_r == jsu_pkg::M_PU) ? jsu_pkg::M_LOW : jsu_pkg::M_HEX;
          accum_nxt = '0;
          cnt_nxt   = '0;
        end else if (esc_ok) begin
          mode_nxt = jsu_pkg::M_STR;
        end else begin
          mode_nxt = jsu_pkg::M_ERR;
        end
      end
      jsu_pkg::M_HEX, jsu_pkg::M_LOW: begin
        if (!hexv) begin
          mode_nxt = jsu_pkg::M_ERR;
        end else if (hex_done) begin
          cnt_nxt   = '0;
          accum_nxt = '0;
          if (mode_r == jsu_pkg::M_HEX && new_hi) begin
            hh_nxt   = acc_new;
            mode_nxt = jsu_pkg::M_PBS;
          end else begin
            if (mode_r == jsu_pkg::M_LOW) hh_nxt = '0;
            mode_nxt = jsu_pkg::M_STR;
          end
        end else begin
          accum_nxt = acc_new;
          cnt_nxt   = cnt_r + 2'd1;
        end
      end
      default: mode_nxt = jsu_pkg::M_ERR;
    endcase
    if (in_data.end_of_text) begin
      mode_nxt  = jsu_pkg::M_IDLE;
      accum_nxt = '0;
      cnt_nxt   = '0;
      hh_nxt    = '0;
    end
  end

  logic        do_cp, do_fffd, do_chr;
  logic [20:0] cp;
  logic [7:0]  chr;
  logic [1:0]  st;

  // Outputs of the step
  always_comb begin
    do_cp   = 1'b0;
    do_fffd = 1'b0;
    do_chr  = 1'b0;
    cp      = '0;
    chr     = c;
    st      = (mode_r == jsu_pkg::M_ERR) ? jsu_pkg::ST_ERR : jsu_pkg::ST_BUSY;
    unique case (mode_r)
      jsu_pkg::M_IDLE: if (c != CH_QUOTE) st = jsu_pkg::ST_ERR;
      jsu_pkg::M_STR, jsu_pkg::M_PBS: begin
        do_fffd = (mode_r == jsu_pkg::M_PBS) && (c != CH_BSLASH);
        if (c == CH_QUOTE) st = jsu_pkg::ST_DONE;
        else if (c != CH_BSLASH) do_chr = 1'b1;
      end
      jsu_pkg::M_ESC, jsu_pkg::M_PU: begin
        do_fffd = (mode_r == jsu_pkg::M_PU) && (c != CH_U);
        if (c != CH_U) begin
          if (esc_ok) begin
            do_chr = 1'b1;
            chr    = esc_chr;
          end else begin
            st = jsu_pkg::ST_ERR;
          end
        end
      end
      jsu_pkg::M_HEX, jsu_pkg::M_LOW: begin
        if (!hexv) begin
          st = jsu_pkg::ST_ERR;
        end else if (hex_done) begin
          if (mode_r == jsu_pkg::M_HEX) begin
            do_cp = !new_hi;
            cp    = new_lo ? REPL_CP : {5'b00000, acc_new};
          end else begin
            do_cp = 1'b1;
            cp    = new_lo ? pair_cp : REPL_CP;
          end
        end
      end
      default: st = jsu_pkg::ST_ERR;
    endcase
    if (in_data.end_of_text && st != jsu_pkg::ST_DONE) st = jsu_pkg::ST_ERR;
  end

  enc_t enc_cp, enc_repl;
  logic [2:0] n;

  assign enc_cp   = utf8_enc(cp);
  assign enc_repl = utf8_enc(REPL_CP);

  // Pack the bytes of the step; replacement char comes before the plain byte.
  always_comb begin
    res.bytes = '0;
    n         = 3'd0;
    if (do_cp) begin
      res.bytes = enc_cp.bytes;
      n         = enc_cp.count;
    end else begin
      if (do_fffd) begin
        res.bytes = enc_repl.bytes;
        n         = enc_repl.count;
      end
      if (do_chr) begin
        res.bytes[n[1:0]] = chr;
        n = n + 3'd1;
      end
    end
    res.has_bytes = (n != 3'd0);
    res.last      = (n == 3'd0) ? 2'd0 : 2'(n - 3'd1);
    res.status    = st;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= jsu_pkg::M_IDLE;
      accum_r <= '0;
      cnt_r   <= '0;
      hh_r    <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      accum_r <= accum_nxt;
      cnt_r   <= cnt_nxt;
      hh_r    <= hh_nxt;
    end
  end

endmodule

>>> hdl/jsu_outbuf.sv
// Result register: holds one decoded group and hands out its bytes one transfer at a time.
module jsu_outbuf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  jsu_pkg::res_t res,
  output logic          busy,
  output logic          out_valid,
  input  logic          out_stall,
  output jsu_pkg::out_t out_data
);

  logic            valid_r;
  logic [1:0]      idx_r;
  logic [3:0][7:0] bytes_r;
  logic [1:0]      last_r;
  logic            has_r;
  logic [1:0]      st_r;
  logic            xfer, last_xfer;

  assign xfer      = valid_r && !out_stall;
  assign last_xfer = xfer && (idx_r == last_r);
  // Busy only while results remain after this cycle's transfer.
  assign busy      = valid_r && !last_xfer;

  assign out_valid           = valid_r;
  assign out_data.out_byte   = has_r ? bytes_r[idx_r] : 8'h00;
  assign out_data.byte_valid = has_r;
  assign out_data.run_last   = (idx_r == last_r);
  assign out_data.status     = st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (last_xfer) begin
      valid_r <= 1'b0;
    end else if (xfer) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r <= res.bytes;
      last_r  <= res.last;
      has_r   <= res.has_bytes;
      st_r    <= res.status;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> idx_r <= last_r)
    else $error("result index past last byte");

  a_group_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.run_last |=> out_valid && idx_r != 2'd0)
    else $error("result group cut short");

  a_empty_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.byte_valid |-> out_data.run_last && out_data.out_byte == 8'h00)
    else $error("empty result not a single zero entry");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status != 2'd3)
    else $error("undefined status code");

endmodule

>>> hdl/json_string_unescape_utf8.sv
// JSON string unescaper: raw quoted-string bytes in, UTF-8 value bytes out.
// Each accepted byte yields a group of one to four results; a byte that
// decodes to nothing gives a single result with byte_valid low, and run_last
// marks the end of each group. A group of n results takes n output transfers
// from the single result register, so with out_stall low the input takes one
// byte per cycle while groups are single results and waits out larger groups.
// The next byte is taken in the same cycle that the last result of the previous
// group transfers, so unstalled plain characters run at one byte per clock.
module json_string_unescape_utf8 (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  jsu_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output jsu_pkg::out_t out_data
);

  jsu_pkg::res_t res;
  logic          busy;
  logic          accept;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  jsu_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .res     (res)
  );

  jsu_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .res       (res),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
